>>> design/cppt_pkg.sv
package cppt_pkg;

    localparam int PAGE_BITS = 12;
    localparam int ADDR_W    = 64;
    localparam int PAGE_W    = ADDR_W - PAGE_BITS;
    localparam int CTX_W     = 8;

    typedef logic [1:0] op_t;
    localparam op_t OP_CREATE    = 2'd0;
    localparam op_t OP_MAP       = 2'd1;
    localparam op_t OP_UNMAP     = 2'd2;
    localparam op_t OP_TRANSLATE = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_EXISTS     = 3'd1;
    localparam status_t ST_UNALIGNED  = 3'd2;
    localparam status_t ST_ALREADY    = 3'd3;
    localparam status_t ST_NOT_MAPPED = 3'd4;
    localparam status_t ST_UNKNOWN    = 3'd5;
    localparam status_t ST_FULL       = 3'd6;

    typedef struct packed {
        logic               valid;
        logic [CTX_W-1:0]   ctx;
        logic [PAGE_W-1:0]  vpage;
        logic [PAGE_W-1:0]  ppage;
    } entry_t;

endpackage

>>> design/context_page_translation_table.sv
// Channel   Direction  Beat contents
// s_axis    in         tuser: operation; tdata: context_id, port_index, virt_addr,
//                      phys_addr, base_addr
// m_axis    out        tuser: status, was_mapped; tdata: translated_addr,
//                      translated_base
// cfg       in         cfg_addr selects port<n>_context, cfg_data is the new value
//
// Create requests and requests rejected in CHECK go straight to DONE, which loads the result;
// map, unmap and translate first scan the entry memory one entry per cycle in SCAN. The next
// input beat is taken once the result is loaded. The context memory lookup in CHECK and the
// registered entry memory read lie on this path.
// After reset a clearing pass over the larger of TABLE_ENTRIES and NUM_CONTEXTS entries
// (256 by default) runs before s_axis_tready.
// A stalled result waits in the output register; the next beat is taken meanwhile.
module context_page_translation_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int NUM_PORTS     = 4,
    parameter int NUM_CONTEXTS  = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [7:0] context_id, [9:8] port_index, [73:10] virt_addr,
    // [137:74] phys_addr, [201:138] base_addr
    input  logic [207:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [63:0] translated_addr, [127:64] translated_base
    output logic [127:0]  m_axis_tdata,
    // [2:0] status, [3] was_mapped
    output logic [3:0]    m_axis_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_addr,
    input  logic [7:0]    cfg_data
);

    localparam int IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
    localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int CTX_IDX_W  = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int CLR_N      = (TABLE_ENTRIES > NUM_CONTEXTS) ? TABLE_ENTRIES : NUM_CONTEXTS;
    localparam int CLR_W      = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int CLR_CMP_W  = CLR_W + 1;
    localparam int PB         = cppt_pkg::PAGE_BITS;
    localparam int PW         = cppt_pkg::PAGE_W;
    localparam int CW         = cppt_pkg::CTX_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [CLR_W-1:0]        clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]        scan_addr_reg, scan_addr_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic [PW-1:0]           hit_ppage_reg, hit_ppage_next;
    logic                    free_reg, free_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;
    cppt_pkg::op_t           req_op_reg, req_op_next;
    logic [CW-1:0]           req_ctx_reg, req_ctx_next;
    logic [PW-1:0]           req_vpage_reg, req_vpage_next;
    logic [PW-1:0]           req_ppage_reg, req_ppage_next;
    logic [PB-1:0]           req_voff_reg, req_voff_next;
    logic [PB-1:0]           req_boff_reg, req_boff_next;
    logic                    req_port_ok_reg, req_port_ok_next;
    logic                    req_pa_unal_reg, req_pa_unal_next;
    cppt_pkg::status_t       pre_status_reg, pre_status_next;
    logic [CW-1:0]           port_ctx_reg [NUM_PORTS];

    logic                    ctx_exists_mem [NUM_CONTEXTS];
    logic                    ctx_rdata_reg;

    logic                    out_valid_reg, out_valid_next;
    cppt_pkg::status_t       out_status_reg, out_status_next;
    logic [63:0]             out_taddr_reg, out_taddr_next;
    logic [63:0]             out_tbase_reg, out_tbase_next;
    logic                    out_mapped_reg, out_mapped_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    cppt_pkg::entry_t        ram_wdata;
    logic                    ram_re;
    cppt_pkg::entry_t        ram_rdata;

    logic                    ctx_we;
    logic [CTX_IDX_W-1:0]    ctx_waddr;
    logic                    ctx_wdata;
    logic                    ctx_re;

    cppt_pkg::op_t           in_op;
    logic [CW-1:0]           in_ctx_field;
    logic [1:0]              in_port;
    logic [63:0]             in_va;
    logic [63:0]             in_pa;
    logic [63:0]             in_ba;
    logic                    in_port_ok;
    logic [CW-1:0]           in_ctx;
    logic                    chk_ctx_range;
    logic                    chk_ctx_known;
    logic                    accept;
    logic                    out_free;
    logic                    entry_match;
    logic                    scan_end;
    cppt_pkg::status_t       fin_status;
    logic [PW-1:0]           fin_page;

    assign in_op        = s_axis_tuser;
    assign in_ctx_field = s_axis_tdata[7:0];
    assign in_port      = s_axis_tdata[9:8];
    assign in_va        = s_axis_tdata[73:10];
    assign in_pa        = s_axis_tdata[137:74];
    assign in_ba        = s_axis_tdata[201:138];

    assign in_port_ok   = {1'b0, in_port} < 3'(NUM_PORTS);
    assign in_ctx       = (in_op == cppt_pkg::OP_TRANSLATE)
                          ? port_ctx_reg[in_port[PORT_IDX_W-1:0]] : in_ctx_field;

    assign chk_ctx_range = {1'b0, req_ctx_reg} < 9'(NUM_CONTEXTS);
    assign chk_ctx_known = chk_ctx_range && ctx_rdata_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign entry_match = ram_rdata.valid && (ram_rdata.ctx == req_ctx_reg)
                         && (ram_rdata.vpage == req_vpage_reg);
    assign scan_end    = (scan_addr_reg == CNT_W'(TABLE_ENTRIES));

    assign ram_re = (state_reg == S_SCAN) && !scan_end;
    assign ctx_re = (state_reg == S_IDLE);

    cppt_entry_ram #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_addr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctx_we)
        begin
            ctx_exists_mem[ctx_waddr] <= ctx_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctx_re)
        begin
            ctx_rdata_reg <= ctx_exists_mem[in_ctx[CTX_IDX_W-1:0]];
        end
    end

    always_comb
    begin
        fin_status = pre_status_reg;
        if (pre_status_reg == cppt_pkg::ST_OK)
        begin
            unique case (req_op_reg)
                cppt_pkg::OP_MAP:
                begin
                    if (hit_reg)
                    begin
                        fin_status = cppt_pkg::ST_ALREADY;
                    end
                    else if (!free_reg)
                    begin
                        fin_status = cppt_pkg::ST_FULL;
                    end
                end
                cppt_pkg::OP_UNMAP:
                begin
                    if (!hit_reg)
                    begin
                        fin_status = cppt_pkg::ST_NOT_MAPPED;
                    end
                end
                default:
                begin
                    fin_status = cppt_pkg::ST_OK;
                end
            endcase
        end
        fin_page = hit_reg ? hit_ppage_reg : req_vpage_reg;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg[IDX_W-1:0];
        ram_wdata = '0;
        ctx_we    = 1'b0;
        ctx_waddr = clr_addr_reg[CTX_IDX_W-1:0];
        ctx_wdata = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            ram_we = ({1'b0, clr_addr_reg} < CLR_CMP_W'(TABLE_ENTRIES));
            ctx_we = ({1'b0, clr_addr_reg} < CLR_CMP_W'(NUM_CONTEXTS));
        end
        else if (state_reg == S_DONE && out_free && fin_status == cppt_pkg::ST_OK)
        begin
            if (req_op_reg == cppt_pkg::OP_MAP)
            begin
                ram_we          = 1'b1;
                ram_waddr       = free_idx_reg;
                ram_wdata.valid = 1'b1;
                ram_wdata.ctx   = req_ctx_reg;
                ram_wdata.vpage = req_vpage_reg;
                ram_wdata.ppage = req_ppage_reg;
            end
            else if (req_op_reg == cppt_pkg::OP_UNMAP)
            begin
                ram_we    = 1'b1;
                ram_waddr = hit_idx_reg;
            end
            else if (req_op_reg == cppt_pkg::OP_CREATE)
            begin
                ctx_we    = 1'b1;
                ctx_waddr = req_ctx_reg[CTX_IDX_W-1:0];
                ctx_wdata = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        scan_addr_next   = scan_addr_reg;
        rd_pend_next     = 1'b0;
        rd_idx_next      = rd_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_ppage_next   = hit_ppage_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        req_op_next      = req_op_reg;
        req_ctx_next     = req_ctx_reg;
        req_vpage_next   = req_vpage_reg;
        req_ppage_next   = req_ppage_reg;
        req_voff_next    = req_voff_reg;
        req_boff_next    = req_boff_reg;
        req_port_ok_next = req_port_ok_reg;
        req_pa_unal_next = req_pa_unal_reg;
        pre_status_next  = pre_status_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_taddr_next   = out_taddr_reg;
        out_tbase_next   = out_tbase_reg;
        out_mapped_next  = out_mapped_reg;

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + CLR_W'(1);
                if (clr_addr_reg == CLR_W'(CLR_N - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    req_op_next      = in_op;
                    req_ctx_next     = in_ctx;
                    req_vpage_next   = in_va[63:PB];
                    req_ppage_next   = in_pa[63:PB];
                    req_voff_next    = in_va[PB-1:0];
                    req_boff_next    = in_ba[PB-1:0];
                    req_port_ok_next = in_port_ok;
                    req_pa_unal_next = (in_pa[PB-1:0] != '0);
                    scan_addr_next   = '0;
                    hit_next         = 1'b0;
                    free_next        = 1'b0;
                    state_next       = S_CHECK;
                end
            end
            S_CHECK:
            begin
                unique case (req_op_reg)
                    cppt_pkg::OP_CREATE:
                    begin
                        if (!chk_ctx_range)
                        begin
                            pre_status_next = cppt_pkg::ST_UNKNOWN;
                        end
                        else if (chk_ctx_known)
                        begin
                            pre_status_next = cppt_pkg::ST_EXISTS;
                        end
                        else
                        begin
                            pre_status_next = cppt_pkg::ST_OK;
                        end
                    end
                    cppt_pkg::OP_MAP:
                    begin
                        if (!chk_ctx_known)
                        begin
                            pre_status_next = cppt_pkg::ST_UNKNOWN;
                        end
                        else if (req_voff_reg != '0 || req_pa_unal_reg)
                        begin
                            pre_status_next = cppt_pkg::ST_UNALIGNED;
                        end
                        else
                        begin
                            pre_status_next = cppt_pkg::ST_OK;
                        end
                    end
                    cppt_pkg::OP_UNMAP:
                    begin
                        if (!chk_ctx_known)
                        begin
                            pre_status_next = cppt_pkg::ST_UNKNOWN;
                        end
                        else if (req_voff_reg != '0)
                        begin
                            pre_status_next = cppt_pkg::ST_UNALIGNED;
                        end
                        else
                        begin
                            pre_status_next = cppt_pkg::ST_OK;
                        end
                    end
                    default:
                    begin
                        if (!req_port_ok_reg || !chk_ctx_known)
                        begin
                            pre_status_next = cppt_pkg::ST_UNKNOWN;
                        end
                        else
                        begin
                            pre_status_next = cppt_pkg::ST_OK;
                        end
                    end
                endcase
                if (req_op_reg == cppt_pkg::OP_CREATE || pre_status_next != cppt_pkg::ST_OK)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!scan_end)
                begin
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = scan_addr_reg[IDX_W-1:0];
                end
                if (rd_pend_reg)
                begin
                    if (entry_match && !hit_reg)
                    begin
                        hit_next       = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                        hit_ppage_next = ram_rdata.ppage;
                    end
                    if (!ram_rdata.valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                end
                else if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fin_status;
                    out_taddr_next  = '0;
                    out_tbase_next  = '0;
                    out_mapped_next = 1'b0;
                    if (fin_status == cppt_pkg::ST_OK && req_op_reg == cppt_pkg::OP_TRANSLATE)
                    begin
                        out_taddr_next  = {fin_page, req_voff_reg};
                        out_tbase_next  = {fin_page, req_boff_reg};
                        out_mapped_next = hit_reg;
                    end
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            scan_addr_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            scan_addr_reg  <= scan_addr_next;
            rd_pend_reg    <= rd_pend_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        hit_idx_reg     <= hit_idx_next;
        hit_ppage_reg   <= hit_ppage_next;
        free_idx_reg    <= free_idx_next;
        req_op_reg      <= req_op_next;
        req_ctx_reg     <= req_ctx_next;
        req_vpage_reg   <= req_vpage_next;
        req_ppage_reg   <= req_ppage_next;
        req_voff_reg    <= req_voff_next;
        req_boff_reg    <= req_boff_next;
        req_port_ok_reg <= req_port_ok_next;
        req_pa_unal_reg <= req_pa_unal_next;
        pre_status_reg  <= pre_status_next;
        out_status_reg  <= out_status_next;
        out_taddr_reg   <= out_taddr_next;
        out_tbase_reg   <= out_tbase_next;
        out_mapped_reg  <= out_mapped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                port_ctx_reg[p] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready && ({1'b0, cfg_addr} < 3'(NUM_PORTS)))
        begin
            port_ctx_reg[cfg_addr[PORT_IDX_W-1:0]] <= cfg_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_tbase_reg, out_taddr_reg};
    assign m_axis_tuser  = {out_mapped_reg, out_status_reg};

endmodule

>>> design/cppt_entry_ram.sv
module cppt_entry_ram #(
    parameter int DEPTH  = 64,
    parameter int IDX_W  = 6
) (
    input  logic                clk,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  cppt_pkg::entry_t    wdata,
    input  logic                re,
    input  logic [IDX_W-1:0]    raddr,
    output cppt_pkg::entry_t    rdata
);

    cppt_pkg::entry_t mem [DEPTH];
    cppt_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
